### design/gpop_pkg.sv
// Shared types, widths and helper functions for the grid path obstruction probe.
// No dependencies; every other file of the block but gpop_ram refers to it by scoped names.
package gpop_pkg;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;
  localparam int CELL_W     = 9;
  localparam int DIST_W     = 13;

  localparam logic CMD_MARK  = 1'b0;
  localparam logic CMD_PROBE = 1'b1;

  typedef enum logic [1:0] {
    KIND_MARK  = 2'd0,
    KIND_ZERO  = 2'd1,
    KIND_PROBE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic signed [15:0]   pos_x;
    logic signed [15:0]   pos_y;
    logic signed [15:0]   dir_x;
    logic signed [15:0]   dir_y;
    logic [DIST_W-1:0]    distance;
  } item_t;

  // Integer cell of a Q8.8 value, truncated toward zero.
  function automatic logic signed [CELL_W-1:0] cell_of(input logic signed [15:0] q);
    logic signed [16:0] w;
    logic signed [16:0] a;
    logic signed [9:0]  m;
    w = {q[15], q};
    a = -w;
    m = -$signed({1'b0, a[16:8]});
    if (q[15]) begin
      cell_of = m[8:0];
    end else begin
      cell_of = {1'b0, q[15:8]};
    end
  endfunction

  // Saturate a wide signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage

### design/gpop_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the occupancy bitmap.
module gpop_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/gpop_front.sv
// Input side: takes stream transactions, unpacks and classifies each item.
// Depends on gpop_pkg for the item record and kind codes.
module gpop_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [gpop_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic                          q_full,
  output logic                          push,
  output gpop_pkg::item_t               item
);

  always_comb begin
    item.pos_x    = s_tdata[15:0];
    item.pos_y    = s_tdata[31:16];
    item.dir_x    = s_tdata[47:32];
    item.dir_y    = s_tdata[63:48];
    item.distance = s_tdata[76:64];
    if (s_tuser == gpop_pkg::CMD_MARK) begin
      item.kind = gpop_pkg::KIND_MARK;
    end else if (s_tdata[63:32] == 32'd0) begin
      item.kind = gpop_pkg::KIND_ZERO;
    end else begin
      item.kind = gpop_pkg::KIND_PROBE;
    end
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

endmodule

### design/gpop_queue.sv
// Two-entry queue of classified items between the front and back parts.
// Depends on gpop_pkg for the item record.
module gpop_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gpop_pkg::item_t push_item,
  input  logic            pop,
  output gpop_pkg::item_t head,
  output logic            full,
  output logic            empty
);

  gpop_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head  = slots[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

endmodule

### design/gpop_back.sv
// Execution side: clears and marks the bitmap, normalizes the direction with
// an iterative root and two shift-subtract dividers, then walks the path.
// Depends on gpop_pkg and gpop_ram.
module gpop_back #(
  parameter int GRID_W      = 64,
  parameter int GRID_H      = 64,
  parameter int MAX_SAMPLES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  gpop_pkg::item_t                 head,
  input  logic                            empty,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [gpop_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]                      m_tuser,
  output logic                            m_tlast
);

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_SAMPLES);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_ZERO  = 11'b000_0000_0100,
    S_PREP  = 11'b000_0000_1000,
    S_SUM   = 11'b000_0001_0000,
    S_ROOT  = 11'b000_0010_0000,
    S_DIV   = 11'b000_0100_0000,
    S_WALK  = 11'b000_1000_0000,
    S_WCHK  = 11'b001_0000_0000,
    S_ECHK  = 11'b010_0000_0000,
    S_SPARE = 11'b100_0000_0000
  } state_t;

  state_t state;

  gpop_pkg::item_t cur;
  logic [AW-1:0]   clr_addr;
  logic [31:0]     sq_x, sq_y;
  logic signed [29:0] prod_x, prod_y;
  logic signed [31:0] end_x, end_y;
  logic [47:0]     root_n, root_res, root_bit;
  logic [23:0]     divisor;
  logic [39:0]     num_x, num_y;
  logic [23:0]     rem_x, rem_y;
  logic [5:0]      div_cnt;
  logic signed [17:0] step_x, step_y;
  logic signed [27:0] ax, ay;
  logic [NW-1:0]   n;
  logic signed [gpop_pkg::CELL_W-1:0] cell_x0, cell_y0;
  logic signed [15:0] smp_x, smp_y;
  logic            smp_exempt, smp_in_grid;
  logic [AW-1:0]   addr_hold;

  logic            out_free;
  logic            emit;
  logic            ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]   ram_waddr, ram_raddr;

  // Mark cell taken from the queue head.
  logic signed [gpop_pkg::CELL_W-1:0] mk_cx, mk_cy;
  logic            mk_in_grid;
  logic [AW-1:0]   mk_addr;

  // Sample being set up in S_WALK: walking point or endpoint.
  logic            walking;
  logic signed [15:0] wx, wy;
  logic signed [gpop_pkg::CELL_W-1:0] wcx, wcy;
  logic            w_in_grid;
  logic [AW-1:0]   w_addr;

  // Root step and divider steps.
  logic [47:0]     root_try;
  logic [24:0]     tx, ty;
  logic [15:0]     mag_x, mag_y;
  logic            hit;

  assign out_free = !m_tvalid || m_tready;
  assign emit     = out_free &&
                    (state == S_ZERO || state == S_WCHK || state == S_ECHK);

  always_comb begin
    mk_cx      = gpop_pkg::cell_of(head.pos_x);
    mk_cy      = gpop_pkg::cell_of(head.pos_y);
    mk_in_grid = !mk_cx[gpop_pkg::CELL_W-1] && !mk_cy[gpop_pkg::CELL_W-1] &&
                 (int'(mk_cx) < GRID_W) && (int'(mk_cy) < GRID_H);
    mk_addr    = AW'(int'(mk_cy) * GRID_W + int'(mk_cx));
  end

  always_comb begin
    walking = (int'(n) < MAX_SAMPLES - 1) &&
              ((32'(n) << 7) < 32'(cur.distance));
    if (walking) begin
      wx = gpop_pkg::sat16(32'(ax >>> 8));
      wy = gpop_pkg::sat16(32'(ay >>> 8));
    end else begin
      wx = gpop_pkg::sat16(end_x >>> 8);
      wy = gpop_pkg::sat16(end_y >>> 8);
    end
    wcx       = gpop_pkg::cell_of(wx);
    wcy       = gpop_pkg::cell_of(wy);
    w_in_grid = !wcx[gpop_pkg::CELL_W-1] && !wcy[gpop_pkg::CELL_W-1] &&
                (int'(wcx) < GRID_W) && (int'(wcy) < GRID_H);
    w_addr    = AW'(int'(wcy) * GRID_W + int'(wcx));
  end

  always_comb begin
    root_try = root_res + root_bit;
    tx       = {rem_x, num_x[39]};
    ty       = {rem_y, num_y[39]};
    mag_x    = cur.dir_x[15] ? 16'(-cur.dir_x) : cur.dir_x;
    mag_y    = cur.dir_y[15] ? 16'(-cur.dir_y) : cur.dir_y;
    hit      = !smp_exempt && smp_in_grid && ram_rdata;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mk_addr;
    ram_wdata = 1'b1;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 1'b0;
    end else if (state == S_IDLE && !empty && head.kind == gpop_pkg::KIND_MARK) begin
      ram_we = mk_in_grid;
    end
    ram_raddr = (state == S_WALK) ? w_addr : addr_hold;
  end

  assign pop = (state == S_IDLE) && !empty;

  gpop_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (int'(clr_addr) == DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty) begin
            case (head.kind)
              gpop_pkg::KIND_ZERO:  state <= S_ZERO;
              gpop_pkg::KIND_PROBE: state <= S_PREP;
              default:              state <= S_IDLE;
            endcase
          end
        end
        S_ZERO: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_PREP:  state <= S_SUM;
        S_SUM:   state <= S_ROOT;
        S_ROOT: begin
          if (root_bit == 48'd0) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == 6'd40) begin
            state <= S_WALK;
          end
        end
        S_WALK: state <= walking ? S_WCHK : S_ECHK;
        S_WCHK: begin
          if (out_free) begin
            state <= hit ? S_IDLE : S_WALK;
          end
        end
        S_ECHK: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur     <= head;
        cell_x0 <= mk_cx;
        cell_y0 <= mk_cy;
      end
      S_ZERO: begin
        if (out_free) begin
          m_tdata <= '0;
          m_tuser <= 2'b00;
          m_tlast <= 1'b1;
        end
      end
      S_PREP: begin
        sq_x   <= 32'(cur.dir_x * cur.dir_x);
        sq_y   <= 32'(cur.dir_y * cur.dir_y);
        prod_x <= 30'($signed({1'b0, cur.distance}) * cur.dir_x);
        prod_y <= 30'($signed({1'b0, cur.distance}) * cur.dir_y);
      end
      S_SUM: begin
        root_n   <= {sq_x + sq_y, 16'd0};
        root_res <= '0;
        root_bit <= 48'd1 << 46;
        end_x    <= 32'($signed({cur.pos_x, 8'd0})) + 32'(prod_x);
        end_y    <= 32'($signed({cur.pos_y, 8'd0})) + 32'(prod_y);
        ax       <= 28'($signed({cur.pos_x, 8'd0}));
        ay       <= 28'($signed({cur.pos_y, 8'd0}));
        n        <= '0;
      end
      S_ROOT: begin
        if (root_bit == 48'd0) begin
          divisor <= root_res[23:0];
          num_x   <= {1'b0, mag_x, 23'd0} + 40'(root_res[23:1]);
          num_y   <= {1'b0, mag_y, 23'd0} + 40'(root_res[23:1]);
          rem_x   <= '0;
          rem_y   <= '0;
          div_cnt <= '0;
        end else begin
          if (root_n >= root_try) begin
            root_n   <= root_n - root_try;
            root_res <= (root_res >> 1) + root_bit;
          end else begin
            root_res <= root_res >> 1;
          end
          root_bit <= root_bit >> 2;
        end
      end
      S_DIV: begin
        if (div_cnt == 6'd40) begin
          // The rounded quotient never exceeds 17 bits.
          step_x <= cur.dir_x[15] ? -$signed({1'b0, num_x[16:0]})
                                  :  $signed({1'b0, num_x[16:0]});
          step_y <= cur.dir_y[15] ? -$signed({1'b0, num_y[16:0]})
                                  :  $signed({1'b0, num_y[16:0]});
        end else begin
          div_cnt <= div_cnt + 6'd1;
          if (tx >= {1'b0, divisor}) begin
            rem_x <= 24'(tx - {1'b0, divisor});
            num_x <= {num_x[38:0], 1'b1};
          end else begin
            rem_x <= tx[23:0];
            num_x <= {num_x[38:0], 1'b0};
          end
          if (ty >= {1'b0, divisor}) begin
            rem_y <= 24'(ty - {1'b0, divisor});
            num_y <= {num_y[38:0], 1'b1};
          end else begin
            rem_y <= ty[23:0];
            num_y <= {num_y[38:0], 1'b0};
          end
        end
      end
      S_WALK: begin
        smp_x       <= wx;
        smp_y       <= wy;
        smp_in_grid <= w_in_grid;
        smp_exempt  <= walking && (wcx == cell_x0) && (wcy == cell_y0);
        addr_hold   <= w_addr;
      end
      S_WCHK: begin
        if (out_free) begin
          m_tdata <= {smp_y, smp_x};
          m_tuser <= {hit, 1'b1};
          m_tlast <= hit;
          ax      <= ax + 28'(step_x);
          ay      <= ay + 28'(step_y);
          n       <= n + NW'(1);
        end
      end
      S_ECHK: begin
        if (out_free) begin
          m_tdata <= {smp_y, smp_x};
          m_tuser <= {hit, 1'b1};
          m_tlast <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### design/grid_path_obstruction_probe.sv
// Top level of the grid path obstruction probe: front, queue and back parts.
// Depends on gpop_pkg, gpop_front, gpop_queue, gpop_back and gpop_ram.
//
//   Channel   Direction  Transaction
//   s_*       in         one mark or probe item (tuser = command)
//   m_*       out        one sample result (tlast ends a probe)
//
// In the back part a mark is written straight from the queue head in S_IDLE.
// A probe is set up by 24 root steps, then 40 steps of the two parallel dividers,
// then walked one sample at a time: S_WALK addresses the single bitmap read port,
// S_WCHK checks and emits the sample. After reset the bitmap is swept clear cell
// by cell; items are queued but not executed meanwhile. A stalled output holds the
// walk; the two-entry queue keeps accepting items while the back part is busy, until it is full.
module grid_path_obstruction_probe #(
  parameter int GRID_W      = 64,
  parameter int GRID_H      = 64,
  parameter int MAX_SAMPLES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // pos_x, pos_y, dir_x, dir_y, distance, zero pad
  input  logic        s_tuser,  // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // sample_x, sample_y
  output logic [1:0]  m_tuser,  // sample_valid, hit
  output logic        m_tlast
);

  gpop_pkg::item_t push_item, head;
  logic            push, pop, q_full, q_empty;

  gpop_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .item     (push_item)
  );

  gpop_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  gpop_back #(
    .GRID_W      (GRID_W),
    .GRID_H      (GRID_H),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### verif/gpop_checker.sv
// Checker for the grid path obstruction probe: predicts samples from accepted items.
// Depends on the stream ports of grid_path_obstruction_probe and on gpop_pkg for the command codes.
`timescale 1ns / 1ps

module gpop_checker #(
  parameter int GRID_W      = 64,
  parameter int GRID_H      = 64,
  parameter int MAX_SAMPLES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,  // pos_x, pos_y, dir_x, dir_y, distance, zero pad
  input  logic        s_tuser,  // command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,  // sample_x, sample_y
  input  logic [1:0]  m_tuser,  // sample_valid, hit
  input  logic        m_tlast,
  output int          errors,
  output int          pending,
  output int          samples_seen,
  output int          hits_seen
);

  typedef struct {
    logic [15:0] sx;
    logic [15:0] sy;
    logic        sample_valid;
    logic        hit;
    logic        last;
  } sample_t;

  sample_t sample_q[$];
  bit      occupied[GRID_W*GRID_H];

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint half_step(longint d, longint unsigned r);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? -d : d;
    q = ((mag << 23) + r / 2) / r;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Q.16 to Q8.8 by flooring, then clamp to 16 bits.
  function automatic int to_q88(longint v);
    longint q;
    q = v >>> 8;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  function automatic bit solid_at(int cx, int cy);
    if (cx < 0 || cy < 0 || cx >= GRID_W || cy >= GRID_H) return 1'b0;
    return occupied[cy*GRID_W + cx];
  endfunction

  task automatic predict_item(logic cmd, logic [79:0] d);
    int      px, py, dx, dy, c0x, c0y, qx, qy, cx, cy, n;
    longint  path_len, ax, ay, stx, sty;
    longint unsigned r;
    bit      h;
    sample_t e;
    px = $signed(d[15:0]);
    py = $signed(d[31:16]);
    dx = $signed(d[47:32]);
    dy = $signed(d[63:48]);
    path_len = d[76:64];
    c0x = px / 256;
    c0y = py / 256;
    if (cmd == gpop_pkg::CMD_MARK) begin
      if (c0x >= 0 && c0y >= 0 && c0x < GRID_W && c0y < GRID_H)
        occupied[c0y*GRID_W + c0x] = 1'b1;
      return;
    end
    if (dx == 0 && dy == 0) begin
      e = '{16'h0, 16'h0, 1'b0, 1'b0, 1'b1};
      sample_q.insert(sample_q.size(), e);
      return;
    end
    r = root_floor(longint'(longint'(dx)*dx + longint'(dy)*dy) << 16);
    stx = half_step(dx, r);
    sty = half_step(dy, r);
    ax = longint'(px) * 256;
    ay = longint'(py) * 256;
    for (n = 0; n < MAX_SAMPLES - 1 && longint'(n) * 128 < path_len; n++) begin
      qx = to_q88(ax);
      qy = to_q88(ay);
      cx = qx / 256;
      cy = qy / 256;
      h = (cx != c0x || cy != c0y) && solid_at(cx, cy);
      e = '{qx[15:0], qy[15:0], 1'b1, h, h};
      sample_q.insert(sample_q.size(), e);
      if (h) return;
      ax += stx;
      ay += sty;
    end
    // No obstruction on the walk: the endpoint is tested with no start exemption.
    qx = to_q88(longint'(px) * 256 + path_len * dx);
    qy = to_q88(longint'(py) * 256 + path_len * dy);
    h = solid_at(qx / 256, qy / 256);
    e = '{qx[15:0], qy[15:0], 1'b1, h, 1'b1};
    sample_q.insert(sample_q.size(), e);
  endtask

  always @(posedge clk) begin
    sample_t e;
    if (rst) begin
      errors = 0;
      samples_seen = 0;
      hits_seen = 0;
    end else begin
      if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        samples_seen++;
        if (m_tuser[1]) hits_seen++;
        if (sample_q.size() == 0) begin
          $error("unexpected result transaction: data %h user %b last %b",
                 m_tdata, m_tuser, m_tlast);
          errors++;
        end else begin
          e = sample_q.pop_front();
          if (m_tdata[15:0] !== e.sx) begin
            $error("sample_x expected %h actual %h", e.sx, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[31:16] !== e.sy) begin
            $error("sample_y expected %h actual %h", e.sy, m_tdata[31:16]);
            errors++;
          end
          if (m_tuser[0] !== e.sample_valid) begin
            $error("sample_valid expected %b actual %b", e.sample_valid, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== e.hit) begin
            $error("hit expected %b actual %b", e.hit, m_tuser[1]);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $error("last expected %b actual %b", e.last, m_tlast);
            errors++;
          end
        end
      end
    end
    pending = sample_q.size();
  end

endmodule

### verif/tb_grid_path_obstruction_probe.sv
// Testbench top for grid_path_obstruction_probe: directed and random marks and probes.
// Depends on the block's RTL and on gpop_checker, which predicts and compares.
`timescale 1ns / 1ps

module tb_grid_path_obstruction_probe;

  localparam int   N_RANDOM  = 450;
  localparam int   LIMIT     = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        hold_out = 1'b0;
  int          errors, pending, samples_seen, hits_seen;
  int          cycles = 0;
  int          items_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  grid_path_obstruction_probe u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  gpop_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .errors(errors), .pending(pending), .samples_seen(samples_seen), .hits_seen(hits_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("tb_grid_path_obstruction_probe: done, errors");
      $finish;
    end
  end

  // Receiver stall pattern: the mode is chosen by bits 9:8 of the cycle counter.
  always @(posedge clk) begin
    if (hold_out) begin
      m_tready <= 1'b0;
    end else begin
      case (cycles[9:8])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= ($urandom_range(0, 1) == 1);
        2'd2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // One long hold-off of the output while the sender keeps offering items.
  initial begin
    wait (items_sent >= 60);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_out <= 1'b0;
  end

  int burst_left = 0;

  task automatic send_item(logic cmd, logic [15:0] px, logic [15:0] py,
                           logic [15:0] dx, logic [15:0] dy, logic [12:0] len);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, len, dy, dx, py, px};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  function automatic logic [15:0] cell_pos(int lo, int hi);
    return 16'(($urandom_range(0, 2 * (hi - lo)) + 2 * lo) * 128 + $urandom_range(0, 127));
  endfunction

  task automatic random_item();
    logic [15:0] px, py, dx, dy;
    logic [12:0] len;
    int sel;
    sel = $urandom_range(0, 99);
    px = cell_pos(-3, 66);
    py = cell_pos(-3, 66);
    if ($urandom_range(0, 19) == 0) begin
      px = 16'($urandom);
      py = 16'($urandom);
    end
    if (sel < 30) begin
      send_item(gpop_pkg::CMD_MARK, px, py, 16'($urandom), 16'($urandom), 13'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0: begin dx = 16'($signed($urandom_range(0, 32)) - 16); end
        1: begin dx = 16'($signed($urandom_range(0, 2048)) - 1024); end
        default: dx = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: begin dy = 16'($signed($urandom_range(0, 32)) - 16); end
        1: begin dy = 16'($signed($urandom_range(0, 2048)) - 1024); end
        default: dy = 16'($urandom);
      endcase
      if (sel < 34) begin
        dx = '0;
        dy = '0;
      end
      if ($urandom_range(0, 9) == 0) len = 13'($urandom_range(0, 8064));
      else len = 13'($urandom_range(0, 2500));
      send_item(gpop_pkg::CMD_PROBE, px, py, dx, dy, len);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed part: marks at the grid corners, inside it, outside it and on the negative edge.
    send_item(gpop_pkg::CMD_MARK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 13'd0);
    send_item(gpop_pkg::CMD_MARK, 16'h3fff, 16'h3fff, 16'hffff, 16'hffff, 13'h1fff);
    send_item(gpop_pkg::CMD_MARK, 16'h0480, 16'h0200, 16'h1234, 16'h8000, 13'd5);
    send_item(gpop_pkg::CMD_MARK, 16'h4000, 16'h0100, 16'h0, 16'h0, 13'd0);
    send_item(gpop_pkg::CMD_MARK, 16'h8000, 16'h7fff, 16'h0, 16'h0, 13'd0);
    send_item(gpop_pkg::CMD_MARK, 16'hff80, 16'h0a00, 16'h0, 16'h0, 13'd0);
    // Zero direction and zero distance.
    send_item(gpop_pkg::CMD_PROBE, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 13'd300);
    send_item(gpop_pkg::CMD_PROBE, 16'h0480, 16'h0280, 16'h0100, 16'h0000, 13'd0);
    send_item(gpop_pkg::CMD_PROBE, 16'h0010, 16'h0010, 16'h0100, 16'h0100, 13'd0);
    // Walk into a marked cell, leave a solid start cell, start left of zero.
    send_item(gpop_pkg::CMD_PROBE, 16'h0080, 16'h0280, 16'h0100, 16'h0000, 13'd2048);
    send_item(gpop_pkg::CMD_PROBE, 16'h0080, 16'h0080, 16'h0100, 16'h0000, 13'd1024);
    send_item(gpop_pkg::CMD_PROBE, 16'hff80, 16'h0a80, 16'hff00, 16'h0000, 13'd256);
    // Longest distance, extreme directions, extreme positions with overflow.
    send_item(gpop_pkg::CMD_PROBE, 16'h1000, 16'h1000, 16'h7fff, 16'h8000, 13'd8064);
    send_item(gpop_pkg::CMD_PROBE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 13'd8064);
    send_item(gpop_pkg::CMD_PROBE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 13'd8064);
    send_item(gpop_pkg::CMD_PROBE, 16'h3f00, 16'h3f00, 16'h0001, 16'hffff, 13'd8064);
    send_item(gpop_pkg::CMD_PROBE, 16'h2000, 16'h2000, 16'h0000, 16'h8000, 13'd1);
    send_item(gpop_pkg::CMD_PROBE, 16'h0100, 16'h0100, 16'h0055, 16'h00aa, 13'h0f7f);
    for (int i = 0; i < N_RANDOM; i++) random_item();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d items driven, %0d results checked, %0d of them obstructed",
             items_sent, samples_seen, hits_seen);
    if (errors == 0 && pending == 0) begin
      $display("tb_grid_path_obstruction_probe: done, clean");
    end else begin
      $display("tb_grid_path_obstruction_probe: done, errors");
    end
    $finish;
  end

endmodule
